### rtl/acr_pkg.sv
// Shared types, constants and AES round functions for the AES-128 CTR byte engine.
// No dependencies.
package acr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    BK_IDLE,
    BK_CIPHER
  } bk_state_t;

  // One classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    logic [3:0]   pos;
    logic         fresh;   // keystream block must be computed before use
    logic [127:0] ctr;
  } item_t;

  typedef struct packed {
    logic busy;
    logic start;
  } bk_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] round);
    logic [7:0] r;
    case (round)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the previous one; byte 0 sits in bits 127:120
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, sw, n0, n1, n2, n3;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    sw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ sw;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped in the final round), AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0]   sb [16];
    logic [7:0]   t  [16];
    logic [7:0]   m  [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[s[127 - 8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = sb[i + 4*((c + i) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]     = fin ? a0 : (a0 ^ al ^ xtime(a0 ^ a1));
      m[4*c + 1] = fin ? a1 : (a1 ^ al ^ xtime(a1 ^ a2));
      m[4*c + 2] = fin ? a2 : (a2 ^ al ^ xtime(a2 ^ a3));
      m[4*c + 3] = fin ? a3 : (a3 ^ al ^ xtime(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = m[i] ^ rk[127 - 8*i -: 8];
    end
    return o;
  endfunction

endpackage

### rtl/acr_front.sv
// Front end: accepts bytes, tracks counter and block position, tags each byte.
// Depends on acr_pkg.
module acr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 chunk_start,
  input  logic [62:0]          chunk_offset,
  input  logic                 chunk_last,
  input  logic [127:0]         iv,
  input  logic                 key_wr,
  output acr_pkg::item_t       item
);

  logic [127:0] cnt_r, cnt_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic         inc_r, inc_nxt;
  logic         need_r, need_nxt;
  logic [127:0] ctr_sel;
  logic [3:0]   pos_sel;

  always_comb begin
    if (chunk_start) begin
      ctr_sel = iv + {69'd0, chunk_offset[62:4]};
      pos_sel = chunk_offset[3:0];
    end else begin
      ctr_sel = inc_r ? (cnt_r + 128'd1) : cnt_r;
      pos_sel = pos_r;
    end
    item.data  = data_byte;
    item.last  = chunk_last;
    item.pos   = pos_sel;
    item.fresh = chunk_start | need_r;
    item.ctr   = ctr_sel;

    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    inc_nxt  = inc_r;
    need_nxt = need_r;
    if (accept) begin
      // advance; a used-up block defers its increment to the next byte
      cnt_nxt  = ctr_sel;
      pos_nxt  = pos_sel + 4'd1;
      inc_nxt  = (pos_sel == 4'hf);
      need_nxt = (pos_sel == 4'hf);
    end else if (key_wr) begin
      need_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pos_r  <= '0;
      inc_r  <= 1'b0;
      need_r <= 1'b1;
    end else begin
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      inc_r  <= inc_nxt;
      need_r <= need_nxt;
    end
  end

endmodule

### rtl/acr_fifo.sv
// Short queue of tagged bytes between front and back.
// Depends on acr_pkg.
module acr_fifo #(
  parameter int unsigned DEPTH = acr_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acr_pkg::item_t wdata,
  input  logic           pop,
  output acr_pkg::item_t head,
  output logic           q_empty,
  output logic           q_full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  acr_pkg::item_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign head    = mem_r[rd_r];
  assign q_empty = (cnt_r == '0);
  assign q_full  = (cnt_r == CntW'(DEPTH));

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/acr_back.sv
// Back end: iterative AES-128 round unit, keystream register and output stage.
// Depends on acr_pkg.
module acr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [127:0]       key,
  input  acr_pkg::item_t     head,
  input  logic               head_valid,
  output logic               head_pop,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_valid,
  input  logic               out_pop,
  output acr_pkg::bk_stat_t  stat
);

  acr_pkg::bk_state_t st_r, st_nxt;
  logic [127:0] blk_r, blk_nxt, rk_r, rk_nxt, ks_r, ks_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         have_r, have_nxt;
  logic         ov_r, ov_nxt;
  logic [7:0]   ob_r, ob_nxt;
  logic         ol_r, ol_nxt;
  logic [127:0] rk_step, blk_step;
  logic         start, take;

  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_valid = ov_r;
  assign head_pop  = take;
  assign stat      = '{busy: (st_r == acr_pkg::BK_CIPHER), start: start};

  always_comb begin
    rk_step  = acr_pkg::key_step(rk_r, acr_pkg::rcon(rnd_r));
    blk_step = acr_pkg::aes_round(blk_r, rk_step, rnd_r == 4'd10);
    start    = (st_r == acr_pkg::BK_IDLE) && head_valid && head.fresh && !have_r;
    take     = head_valid && (!head.fresh || have_r) && (!ov_r || out_pop);

    st_nxt   = st_r;
    blk_nxt  = blk_r;
    rk_nxt   = rk_r;
    rnd_nxt  = rnd_r;
    ks_nxt   = ks_r;
    have_nxt = have_r;
    case (st_r)
      acr_pkg::BK_IDLE: begin
        if (start) begin
          blk_nxt = head.ctr ^ key;
          rk_nxt  = key;
          rnd_nxt = 4'd1;
          st_nxt  = acr_pkg::BK_CIPHER;
        end
      end
      acr_pkg::BK_CIPHER: begin
        blk_nxt = blk_step;
        rk_nxt  = rk_step;
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          ks_nxt   = blk_step;
          have_nxt = 1'b1;
          st_nxt   = acr_pkg::BK_IDLE;
        end
      end
      default: st_nxt = acr_pkg::BK_IDLE;
    endcase
    if (take && head.fresh) begin
      have_nxt = 1'b0;
    end

    ov_nxt = ov_r && !out_pop;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    if (take) begin
      ov_nxt = 1'b1;
      ob_nxt = head.data ^ ks_r[127 - 8*head.pos -: 8];
      ol_nxt = head.last;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    rk_r  <= rk_nxt;
    ks_r  <= ks_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= acr_pkg::BK_IDLE;
      rnd_r  <= '0;
      have_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rnd_r  <= rnd_nxt;
      have_r <= have_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

### rtl/aes128_ctr_stream_cipher.sv
// AES-128 CTR byte engine, top level: config registers, front, queue, back.
// Throughput: one byte per cycle inside a block while the output drains; each byte
// passes the queue and the registered output stage. A new keystream block needs the
// iterative AES round unit (one round per cycle), overlapped with queued bytes upstream.
// Reset (rst_n low, synchronous): key, IV and counter cleared, queue and output emptied.
// Depends on acr_pkg, acr_front, acr_fifo, acr_back.
module aes128_ctr_stream_cipher #(
  parameter int unsigned QUEUE_DEPTH = acr_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_chunk_start,
  input  logic [62:0]                   in_chunk_offset,
  input  logic                          in_chunk_last,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [acr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [acr_pkg::CfgDataW-1:0]  cfg_data
);

  logic [127:0]      key_r, key_nxt, iv_r, iv_nxt;
  logic              key_wr;
  logic              in_xfer;
  logic              q_empty, q_full, q_pop;
  logic              out_valid;
  acr_pkg::item_t    item, head;
  acr_pkg::bk_stat_t stat;

  // Key write voids keystream unless a byte enters too; IV waits for next chunk start
  always_comb begin
    key_nxt = key_r;
    iv_nxt  = iv_r;
    key_wr  = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        {{(acr_pkg::CfgIdxW-2){1'b0}}, acr_pkg::REG_KEY_HIGH}: begin
          key_nxt[127:64] = cfg_data;
          key_wr = 1'b1;
        end
        {{(acr_pkg::CfgIdxW-2){1'b0}}, acr_pkg::REG_KEY_LOW}: begin
          key_nxt[63:0] = cfg_data;
          key_wr = 1'b1;
        end
        {{(acr_pkg::CfgIdxW-2){1'b0}}, acr_pkg::REG_IV_HIGH}: iv_nxt[127:64] = cfg_data;
        {{(acr_pkg::CfgIdxW-2){1'b0}}, acr_pkg::REG_IV_LOW}:  iv_nxt[63:0]   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      iv_r  <= '0;
    end else begin
      key_r <= key_nxt;
      iv_r  <= iv_nxt;
    end
  end

  // Input transfer goes straight into the queue
  assign full    = q_full;
  assign in_xfer = push && !q_full;
  assign empty   = !out_valid;

  acr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .data_byte    (in_data_byte),
    .chunk_start  (in_chunk_start),
    .chunk_offset (in_chunk_offset),
    .chunk_last   (in_chunk_last),
    .iv           (iv_r),
    .key_wr       (key_wr),
    .item         (item)
  );

  acr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_xfer),
    .wdata   (item),
    .pop     (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // Back end holds a byte that opens a block until its keystream is ready
  acr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        (key_r),
    .head       (head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .stat       (stat)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("queue popped while empty");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) stat.start |-> !stat.busy)
    else $error("cipher restarted while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n) stat.start |=> stat.busy)
    else $error("cipher start did not enter round loop");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
      stat.busy |-> !(q_pop && head.fresh))
    else $error("fresh byte consumed before keystream ready");
`endif

endmodule
